// ===== design/interval_stabbing_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Interval stabbing table assertion macros
// Shared concurrent assertion forms used by the table core.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_STABBING_TABLE_CORE_DEFINES_SVH
`define INTERVAL_STABBING_TABLE_CORE_DEFINES_SVH

// check that a condition holds at every clock edge out of reset
`define IST_ASSERT_ALWAYS(label, ck, rs, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// check that a consequent holds in the same cycle as its antecedent
`define IST_ASSERT_IMPLY(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval stabbing table package
// Request, status, register and state codes plus the stored record types.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 64;
  localparam int MAX_RESULTS = 32;
  localparam int MCOUNT_W    = 6;

  localparam logic [20:0] NODE_BYTES_RST   = 21'd4096;
  localparam logic [15:0] HEADER_BYTES_RST = 16'd64;

  typedef enum logic [1:0] {
    REQ_INSERT      = 2'd0,
    REQ_CLOSE       = 2'd1,
    REQ_QUERY_ALL   = 2'd2,
    REQ_QUERY_FIRST = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_NO_ROOM = 2'd2,
    STAT_NONE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_NODE_BEGIN   = 2'd0,
    REG_NODE_BYTES   = 2'd1,
    REG_HEADER_BYTES = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS,
    S_BS_CMP,
    S_SC,
    S_SC_CHK,
    S_DONE
  } state_t;

  typedef logic [5:0] slot_t;

  typedef struct packed {
    logic [63:0] start_time;
    logic [63:0] end_time;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] match_begin;
    logic [63:0] match_end;
    logic [31:0] match_id;
    slot_t       match_slot;
  } rec_t;

endpackage

// ===== design/ist_if.sv =====
// ----------------------------------------------------------------------------
// Interval stabbing table channels
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface ist_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] time_value;
  logic [63:0] iv_begin;
  logic [63:0] iv_end;
  logic [31:0] interval_id;
  logic [15:0] iv_bytes;

  modport source (output valid, req_type, time_value, iv_begin, iv_end, interval_id,
                  iv_bytes, input ready);
  modport sink (input valid, req_type, time_value, iv_begin, iv_end, interval_id,
                iv_bytes, output ready);
endinterface

interface ist_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] match_begin;
  logic [63:0] match_end;
  logic [31:0] match_id;
  logic [5:0]  match_slot;
  logic        last;

  modport source (output valid, status, match_begin, match_end, match_id, match_slot,
                  last, input ready);
  modport sink (input valid, status, match_begin, match_end, match_id, match_slot,
                last, output ready);
endinterface

// ===== design/interval_stabbing_table_core.sv =====
// Insert and close give a single result, presented from the done state. Query: each
//   search probe is a table read and then a compare (up to ceil(log2(count+1)) probes),
//   then the scan reads and checks each entry from the lower bound on until the table
//   ends or a first match or the result cap stops it; output stalls hold it.
// One request at a time; the single table read port sets the query time.
// Reset clears counters and flags and loads the register defaults; table stays unwritten.
// ----------------------------------------------------------------------------
// Interval stabbing table core
// Interval table in one RAM with append, close and stabbing queries.
// ----------------------------------------------------------------------------
`include "interval_stabbing_table_core_defines.svh"

module interval_stabbing_table_core #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  ist_req_if.sink                      req,
  ist_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ist_pkg::PADDR_W-1:0]  paddr,
  input  logic [ist_pkg::PDATA_W-1:0]  pwdata,
  output logic [ist_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  ist_pkg::state_t state, state_next;
  ist_pkg::req_t   cur_type, cur_type_next;

  logic [63:0] node_begin, node_begin_next;
  logic [20:0] node_bytes, node_bytes_next;
  logic [15:0] header_bytes, header_bytes_next;
  logic [CW-1:0] count, count_next;
  logic [20:0] used_bytes, used_bytes_next;
  logic [63:0] node_end, node_end_next;
  logic        closed, closed_next;

  logic [63:0] tv, tv_next;
  logic [31:0] want_id, want_id_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, mid, mid_next, mid_c, idx, idx_next;
  logic [ist_pkg::MCOUNT_W-1:0] mcount, mcount_next;

  ist_pkg::rec_t pend, pend_next, out_rec, out_rec_next, cur_rec, zero_rec;
  logic pend_valid, pend_valid_next;
  logic out_valid, out_valid_next, out_last, out_last_next;

  logic req_fire, out_free, cfg_wr, hit, no_room, full;
  logic [22:0] hdr_used;
  ist_pkg::cfg_reg_t cfg_sel;

  logic ram_we, ram_re;
  logic [IW-1:0] ram_raddr;
  ist_pkg::entry_t ram_wdata, ram_rdata;

  ist_ram #(
    .WIDTH ($bits(ist_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready   = (state == ist_pkg::S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign cfg_wr      = psel && penable && pwrite;
  assign cfg_sel     = ist_pkg::cfg_reg_t'(paddr[4:3]);
  assign pready      = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_rec.status;
  assign rsp.match_begin = out_rec.match_begin;
  assign rsp.match_end   = out_rec.match_end;
  assign rsp.match_id    = out_rec.match_id;
  assign rsp.match_slot  = out_rec.match_slot;
  assign rsp.last        = out_last;

  always_comb begin
    case (cfg_sel)
      ist_pkg::REG_NODE_BEGIN:   prdata = node_begin;
      ist_pkg::REG_NODE_BYTES:   prdata = 64'(node_bytes);
      ist_pkg::REG_HEADER_BYTES: prdata = 64'(header_bytes);
      default:                   prdata = '0;
    endcase
  end

  assign hdr_used = 23'(header_bytes) + 23'(used_bytes);
  assign full     = (count == CW'(DEPTH));
  assign no_room  = full || ((23'(node_bytes) < hdr_used) ? (req.iv_bytes != 16'd0)
                    : (23'(req.iv_bytes) > (23'(node_bytes) - hdr_used)));

  assign mid_c     = lo + ((hi - lo) >> 1);
  assign ram_re    = ((state == ist_pkg::S_BS) && (lo < hi))
                     || ((state == ist_pkg::S_SC) && (idx < count));
  assign ram_raddr = (state == ist_pkg::S_BS) ? mid_c[IW-1:0] : idx[IW-1:0];

  assign ram_wdata.start_time = req.iv_begin;
  assign ram_wdata.end_time   = req.iv_end;
  assign ram_wdata.id         = req.interval_id;

  assign hit = (ram_rdata.start_time <= tv)
               && ((cur_type == ist_pkg::REQ_QUERY_ALL) || (ram_rdata.id == want_id));

  assign zero_rec = '0;

  always_comb begin
    cur_rec.status      = ist_pkg::STAT_OK;
    cur_rec.match_begin = ram_rdata.start_time;
    cur_rec.match_end   = ram_rdata.end_time;
    cur_rec.match_id    = ram_rdata.id;
    cur_rec.match_slot  = ist_pkg::slot_t'(idx[IW-1:0]);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ist_pkg::S_IDLE: begin
        if (req_fire) begin
          if ((req.req_type == ist_pkg::REQ_INSERT) || (req.req_type == ist_pkg::REQ_CLOSE)
              || (count == '0) || (req.time_value < node_begin)
              || (req.time_value > node_end)) begin
            state_next = ist_pkg::S_DONE;
          end else begin
            state_next = ist_pkg::S_BS;
          end
        end
      end
      ist_pkg::S_BS:     state_next = (lo < hi) ? ist_pkg::S_BS_CMP : ist_pkg::S_SC;
      ist_pkg::S_BS_CMP: state_next = ist_pkg::S_BS;
      ist_pkg::S_SC:     state_next = (idx < count) ? ist_pkg::S_SC_CHK : ist_pkg::S_DONE;
      ist_pkg::S_SC_CHK: begin
        if (!hit) begin
          state_next = ist_pkg::S_SC;
        end else if (cur_type == ist_pkg::REQ_QUERY_FIRST) begin
          state_next = ist_pkg::S_DONE;
        end else if (pend_valid && !out_free) begin
          state_next = ist_pkg::S_SC_CHK;
        end else if (mcount == ist_pkg::MCOUNT_W'(ist_pkg::MAX_RESULTS - 1)) begin
          state_next = ist_pkg::S_DONE;
        end else begin
          state_next = ist_pkg::S_SC;
        end
      end
      ist_pkg::S_DONE:   state_next = out_free ? ist_pkg::S_IDLE : ist_pkg::S_DONE;
      default:           state_next = ist_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_type_next     = cur_type;
    node_begin_next   = node_begin;
    node_bytes_next   = node_bytes;
    header_bytes_next = header_bytes;
    count_next        = count;
    used_bytes_next   = used_bytes;
    node_end_next     = node_end;
    closed_next       = closed;
    tv_next           = tv;
    want_id_next      = want_id;
    lo_next           = lo;
    hi_next           = hi;
    mid_next          = mid;
    idx_next          = idx;
    mcount_next       = mcount;
    pend_next         = pend;
    pend_valid_next   = pend_valid;
    out_rec_next      = out_rec;
    out_last_next     = out_last;
    out_valid_next    = out_valid && !rsp.ready;
    ram_we            = 1'b0;

    case (state)
      ist_pkg::S_IDLE: begin
        if (req_fire) begin
          cur_type_next   = ist_pkg::req_t'(req.req_type);
          tv_next         = req.time_value;
          want_id_next    = req.interval_id;
          lo_next         = '0;
          hi_next         = count;
          mcount_next     = '0;
          pend_valid_next = 1'b0;
          pend_next       = zero_rec;
          case (ist_pkg::req_t'(req.req_type))
            ist_pkg::REQ_INSERT: begin
              if (no_room) begin
                pend_next.status = ist_pkg::STAT_NO_ROOM;
              end else if ((count != '0) && (req.iv_end < node_end)) begin
                pend_next.status = ist_pkg::STAT_RANGE;
              end else begin
                ram_we                = 1'b1;
                pend_next.status      = ist_pkg::STAT_OK;
                pend_next.match_begin = req.iv_begin;
                pend_next.match_end   = req.iv_end;
                pend_next.match_id    = req.interval_id;
                pend_next.match_slot  = ist_pkg::slot_t'(count[IW-1:0]);
                used_bytes_next       = used_bytes + 21'(req.iv_bytes);
                node_end_next         = req.iv_end;
                count_next            = count + CW'(1);
              end
            end
            ist_pkg::REQ_CLOSE: begin
              if (closed) begin
                pend_next.status = ist_pkg::STAT_OK;
              end else if (req.time_value < node_end) begin
                pend_next.status = ist_pkg::STAT_RANGE;
              end else begin
                pend_next.status = ist_pkg::STAT_OK;
                closed_next      = 1'b1;
                node_end_next    = req.time_value;
              end
            end
            default: begin
              if (count == '0) begin
                pend_next.status = ist_pkg::STAT_NONE;
              end else if ((req.time_value < node_begin) || (req.time_value > node_end)) begin
                pend_next.status = ist_pkg::STAT_RANGE;
              end
            end
          endcase
        end
      end
      ist_pkg::S_BS: begin
        if (lo < hi) begin
          mid_next = mid_c;
        end else begin
          idx_next = lo;
        end
      end
      ist_pkg::S_BS_CMP: begin
        if (ram_rdata.end_time < tv) begin
          lo_next = mid + CW'(1);
        end else begin
          hi_next = mid;
        end
      end
      ist_pkg::S_SC: begin
        if (!(idx < count) && !pend_valid) begin
          pend_next        = zero_rec;
          pend_next.status = ist_pkg::STAT_NONE;
        end
      end
      ist_pkg::S_SC_CHK: begin
        if (!hit) begin
          idx_next = idx + CW'(1);
        end else if (cur_type == ist_pkg::REQ_QUERY_FIRST) begin
          pend_next = cur_rec;
        end else if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_rec_next   = pend;
            out_last_next  = 1'b0;
          end
          pend_next       = cur_rec;
          pend_valid_next = 1'b1;
          mcount_next     = mcount + ist_pkg::MCOUNT_W'(1);
          idx_next        = idx + CW'(1);
        end
      end
      ist_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_rec_next   = pend;
          out_last_next  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_wr) begin
      case (cfg_sel)
        ist_pkg::REG_NODE_BEGIN: begin
          node_begin_next = pwdata;
          if ((count == '0) && !closed) begin
            node_end_next = pwdata;
          end
        end
        ist_pkg::REG_NODE_BYTES:   node_bytes_next   = pwdata[20:0];
        ist_pkg::REG_HEADER_BYTES: header_bytes_next = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ist_pkg::S_IDLE;
      node_begin   <= '0;
      node_bytes   <= ist_pkg::NODE_BYTES_RST;
      header_bytes <= ist_pkg::HEADER_BYTES_RST;
      count        <= '0;
      used_bytes   <= '0;
      node_end     <= '0;
      closed       <= 1'b0;
      lo           <= '0;
      hi           <= '0;
      idx          <= '0;
      mcount       <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
      cur_type     <= ist_pkg::REQ_INSERT;
    end else begin
      state        <= state_next;
      node_begin   <= node_begin_next;
      node_bytes   <= node_bytes_next;
      header_bytes <= header_bytes_next;
      count        <= count_next;
      used_bytes   <= used_bytes_next;
      node_end     <= node_end_next;
      closed       <= closed_next;
      lo           <= lo_next;
      hi           <= hi_next;
      idx          <= idx_next;
      mcount       <= mcount_next;
      pend_valid   <= pend_valid_next;
      out_valid    <= out_valid_next;
      cur_type     <= cur_type_next;
    end
  end

  always_ff @(posedge clk) begin
    tv       <= tv_next;
    want_id  <= want_id_next;
    mid      <= mid_next;
    pend     <= pend_next;
    out_rec  <= out_rec_next;
    out_last <= out_last_next;
  end

  `IST_ASSERT_ALWAYS(a_count_max, clk, rst, count <= CW'(DEPTH), "entry count above depth")
  `IST_ASSERT_IMPLY(a_search_bounds, clk, rst,
      (state == ist_pkg::S_BS) || (state == ist_pkg::S_BS_CMP), (lo <= hi) && (hi <= count),
      "search bounds out of order")
  `IST_ASSERT_IMPLY(a_partial_all_only, clk, rst, out_valid && !out_last,
      cur_type == ist_pkg::REQ_QUERY_ALL, "non-final result outside query-all")
  `IST_ASSERT_IMPLY(a_count_step, clk, rst, !$past(rst) && (count != $past(count)),
      count == ($past(count) + CW'(1)), "entry count moved by other than one")
  `IST_ASSERT_ALWAYS(a_result_cap, clk, rst,
      mcount <= ist_pkg::MCOUNT_W'(ist_pkg::MAX_RESULTS), "match count above cap")

endmodule

// ===== design/ist_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
